FILE: design/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int CODE_W  = 32;
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 16;
  localparam int ACC_W   = CODE_W + PEND_W;
  localparam int TOT_W   = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2,
    ACT_IDLE   = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [7:0]          symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [5:0]          code_len;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic                last;
    logic [COUNT_W-1:0]  byte_count;
  } out_word_t;

  typedef struct packed {
    logic [ACC_W-1:0]    acc;
    logic [TOT_W-1:0]    total;
    logic                dvalid;
    logic [COUNT_W-1:0]  cnt;
  } emit_req_t;

endpackage

FILE: design/huffman_code_bit_packer_top.sv
// Top level of the Huffman code bit packer: code table, accumulator and byte emitter.
// A word passes the lookup registers, the emitter's run register and the output register.
// Throughput: one input word per cycle while each gives at most one byte and the output
// is not stalled; a longer run holds the input, as the output passes one byte per cycle.
// Reset clears the table's written flags, the accumulator and the byte count;
// input is taken as soon as reset ends, with no clearing pass.
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbp_pkg::out_word_t out_data
);

  localparam int USABLE_LEN = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                 : hcbp_pkg::CODE_W;
  localparam int LEN_W      = $clog2(USABLE_LEN + 1);
  localparam int IDX_W      = $clog2(SYMBOL_COUNT);

  logic                 accept;
  logic                 in_range;
  logic [LEN_W-1:0]     len_sat;
  logic                 wr_en;
  logic                 rd_en;
  logic [USABLE_LEN-1:0] rd_bits;
  logic [LEN_W-1:0]     rd_len;
  logic                 emit_free;
  logic                 emit_push;
  hcbp_pkg::emit_req_t  emit_req;

  always_comb begin
    accept   = in_valid && in_ready;
    in_range = {1'b0, in_data.symbol} < 9'(SYMBOL_COUNT);
    len_sat  = (in_data.code_len > 6'(USABLE_LEN)) ? LEN_W'(USABLE_LEN)
                                                    : LEN_W'(in_data.code_len);
    wr_en    = accept && in_range && (in_data.action == hcbp_pkg::ACT_LOAD);
    rd_en    = accept && in_range && (in_data.action == hcbp_pkg::ACT_ENCODE);
  end

  hcbp_code_mem #(
    .DEPTH  (SYMBOL_COUNT),
    .IDX_W  (IDX_W),
    .BITS_W (USABLE_LEN),
    .LEN_W  (LEN_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (in_data.symbol[IDX_W-1:0]),
    .wr_bits (in_data.code_bits[USABLE_LEN-1:0]),
    .wr_len  (len_sat),
    .rd_en   (rd_en),
    .rd_addr (in_data.symbol[IDX_W-1:0]),
    .rd_bits (rd_bits),
    .rd_len  (rd_len)
  );

  hcbp_packer #(
    .BITS_W (USABLE_LEN),
    .LEN_W  (LEN_W)
  ) u_packer (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (in_data.action),
    .in_range  (in_range),
    .code_bits (rd_bits),
    .code_len  (rd_len),
    .emit_free (emit_free),
    .emit_push (emit_push),
    .emit_req  (emit_req),
    .ready     (in_ready)
  );

  hcbp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .push      (emit_push),
    .req       (emit_req),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/hcbp_code_mem.sv
// Code table memory with per-entry written flags and registered read port.
module hcbp_code_mem #(
  parameter int DEPTH  = 256,
  parameter int IDX_W  = 8,
  parameter int BITS_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [BITS_W-1:0] wr_bits,
  input  logic [LEN_W-1:0]  wr_len,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [BITS_W-1:0] rd_bits,
  output logic [LEN_W-1:0]  rd_len
);

  logic [LEN_W+BITS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]        written;
  logic [LEN_W+BITS_W-1:0] rd_q;
  logic                    rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_len, wr_bits};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  assign rd_bits = rd_q[BITS_W-1:0];
  assign rd_len  = rd_ok ? rd_q[LEN_W+BITS_W-1:BITS_W] : '0;

endmodule

FILE: design/hcbp_packer.sv
// Lookup stage and bit accumulator: merges codes into pending bits and issues byte runs.
module hcbp_packer #(
  parameter int BITS_W = 32,
  parameter int LEN_W  = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  hcbp_pkg::action_t   action,
  input  logic                in_range,
  input  logic [BITS_W-1:0]   code_bits,
  input  logic [LEN_W-1:0]    code_len,
  input  logic                emit_free,
  output logic                emit_push,
  output hcbp_pkg::emit_req_t emit_req,
  output logic                ready
);

  hcbp_pkg::action_t                  s1_action;
  logic                               s1_valid;
  logic                               s1_in_range;
  logic [hcbp_pkg::PEND_W-1:0]        pend;
  logic [hcbp_pkg::PCNT_W-1:0]        pcnt;
  logic [hcbp_pkg::COUNT_W-1:0]       emitted;

  logic [hcbp_pkg::ACC_W-1:0]         low_mask;
  logic [hcbp_pkg::ACC_W-1:0]         acc;
  logic [hcbp_pkg::TOT_W-1:0]         total;
  logic [hcbp_pkg::PCNT_W-1:0]        pcnt_next;
  logic [hcbp_pkg::PEND_W-1:0]        pend_next;
  logic [hcbp_pkg::COUNT_W-1:0]       emitted_next;
  logic                               is_encode;
  logic                               is_flush;
  logic                               need_emit;
  logic                               s1_adv;

  always_comb begin
    low_mask     = ~({hcbp_pkg::ACC_W{1'b1}} << code_len);
    acc          = (hcbp_pkg::ACC_W'(pend) << code_len) |
                   (hcbp_pkg::ACC_W'(code_bits) & low_mask);
    total        = hcbp_pkg::TOT_W'(pcnt) + hcbp_pkg::TOT_W'(code_len);
    pcnt_next    = total[hcbp_pkg::PCNT_W-1:0];
    pend_next    = acc[hcbp_pkg::PEND_W-1:0] & ~({hcbp_pkg::PEND_W{1'b1}} << pcnt_next);
    emitted_next = emitted + hcbp_pkg::COUNT_W'(total[hcbp_pkg::TOT_W-1:3]);
    is_encode    = s1_valid && (s1_action == hcbp_pkg::ACT_ENCODE) && s1_in_range &&
                   (code_len != '0);
    is_flush     = s1_valid && (s1_action == hcbp_pkg::ACT_FLUSH);
    need_emit    = is_flush || (is_encode && (total[hcbp_pkg::TOT_W-1:3] != '0));
    s1_adv       = s1_valid && (!need_emit || emit_free);
    ready        = !s1_valid || s1_adv;
    emit_push    = s1_adv && need_emit;
  end

  always_comb begin
    if (is_flush) begin
      emit_req.total = hcbp_pkg::TOT_W'(8);
      if (pcnt != '0) begin
        emit_req.acc    = hcbp_pkg::ACC_W'(8'(pend) << (4'd8 - 4'(pcnt)));
        emit_req.dvalid = 1'b1;
        emit_req.cnt    = emitted + 16'd1;
      end else begin
        emit_req.acc    = '0;
        emit_req.dvalid = 1'b0;
        emit_req.cnt    = emitted;
      end
    end else begin
      emit_req.acc    = acc;
      emit_req.total  = total;
      emit_req.dvalid = 1'b1;
      emit_req.cnt    = emitted + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action   <= action;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pend     <= '0;
      pcnt     <= '0;
      emitted  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv && is_flush) begin
        pend    <= '0;
        pcnt    <= '0;
        emitted <= '0;
      end else if (s1_adv && is_encode) begin
        pend    <= pend_next;
        pcnt    <= pcnt_next;
        emitted <= emitted_next;
      end
    end
  end

  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (pend & ({hcbp_pkg::PEND_W{1'b1}} << pcnt)) == '0)
    else $error("pending bits above pending count");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    emit_push |-> emit_free)
    else $error("byte run issued while emitter busy");

endmodule

FILE: design/hcbp_emit.sv
// Byte emitter: slices one byte per unstalled cycle from a run into the output register.
module hcbp_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  hcbp_pkg::emit_req_t req,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbp_pkg::out_word_t out_data
);

  logic [hcbp_pkg::ACC_W-1:0]   e_acc;
  logic [hcbp_pkg::TOT_W-1:0]   e_total;
  logic                         e_dvalid;
  logic [hcbp_pkg::COUNT_W-1:0] e_cnt;

  logic [hcbp_pkg::ACC_W-1:0]   shifted;
  logic [hcbp_pkg::TOT_W-1:0]   rem;
  logic                         busy;
  logic                         rem_last;
  logic                         e_go;

  always_comb begin
    busy     = e_total[hcbp_pkg::TOT_W-1:3] != '0;
    rem      = e_total - hcbp_pkg::TOT_W'(8);
    rem_last = rem[hcbp_pkg::TOT_W-1:3] == '0;
    shifted  = e_acc >> rem;
    e_go     = busy && (!out_valid || out_ready);
    free     = !busy || (e_go && rem_last);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      e_acc    <= req.acc;
      e_dvalid <= req.dvalid;
      e_cnt    <= req.cnt;
    end else if (e_go) begin
      e_cnt <= e_cnt + 16'd1;
    end
    if (e_go) begin
      out_data.out_byte   <= shifted[hcbp_pkg::BYTE_W-1:0];
      out_data.byte_valid <= e_dvalid;
      out_data.last       <= rem_last;
      out_data.byte_count <= e_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_total   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push) begin
        e_total <= req.total;
      end else if (e_go) begin
        e_total <= rem;
      end
      if (e_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_empty_flush: assert property (@(posedge clk) disable iff (rst)
    (busy && !e_dvalid) |-> (e_total == hcbp_pkg::TOT_W'(8)))
    else $error("empty flush run longer than one word");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |-> out_data.last)
    else $error("word without data not marked last");

  a_run_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last) |=> out_valid)
    else $error("gap inside a byte run");

endmodule
